FILE: hw/rtl/ccr_pkg.sv
// Shared types and constants for the circle canvas rasterizer.
package ccr_pkg;

  localparam int CFG_W       = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int BYTE_W      = 8;
  localparam int COORD_W     = 20;
  localparam int FRAC_BITS   = 8;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 8;

  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_RADIUS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd2;

  localparam logic [CFG_W-1:0]  WIDTH_RESET      = 9'd256;
  localparam logic [CFG_W-1:0]  HEIGHT_RESET     = 9'd256;
  localparam logic [BYTE_W-1:0] BACKGROUND_RESET = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_SETUP,
    ST_SCAN,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/ccr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/circle_canvas_rasterizer.sv
// Character canvas rasterizer top level.
// Holds a byte canvas of MAX_WIDTH by MAX_HEIGHT pixels in one RAM and runs one command at a
// time: clear fills the rows and columns in use with the background byte, draw tests every
// pixel in use against a circle and paints the covered ones, read returns one stored byte.
// Each command gives exactly one result word. The RAM write port handles one pixel per cycle,
// and clear and draw visit every pixel in use in turn; draw first squares the centre, radius
// and inner radius on one shared multiplier in four setup steps. Squared distances are
// stepped from pixel to pixel by adds alone. The canvas is not cleared by reset: read only
// pixels that a clear or draw has written. The input side is ready whenever no command is
// in progress, also while a result word still waits on the output register.
module circle_canvas_rasterizer import ccr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // center_x[19:0], center_y[39:20], radius[59:40], outline_only[60],
  // paint_byte[68:61], read_row[76:69], read_col[84:77], zero fill
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [OPCODE_W-1:0]    s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pixel_value[7:0]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]    m_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW  = CW + RW;
  localparam int XW  = (CW > RW) ? CW : RW;
  localparam int DMW = (XW + 1 > CFG_W) ? XW + 1 : CFG_W;
  localparam int PW  = ((XW + FRAC_BITS > COORD_W - 1) ? XW + FRAC_BITS : COORD_W - 1) + 2;
  localparam int SW  = 2 * PW;

  localparam logic [PW-1:0]  PIX_STEP = PW'(2 ** FRAC_BITS);
  localparam logic [SW:0]    STEP_SQ  = (SW + 1)'(2 ** (2 * FRAC_BITS));
  localparam logic [DMW-1:0] MAX_COLS = DMW'(MAX_WIDTH);
  localparam logic [DMW-1:0] MAX_ROWS = DMW'(MAX_HEIGHT);

  state_t state, state_next;

  logic [CFG_W-1:0]  canvas_width, canvas_height;
  logic [BYTE_W-1:0] background_byte;

  logic [DMW-1:0] cols_used, rows_used;
  logic           dims_empty;

  logic [COORD_W-1:0] in_cx, in_cy, in_radius;
  logic               in_outline;
  logic [BYTE_W-1:0]  in_paint, in_row, in_col;

  logic signed [PW-1:0] dx0, dx, dy;
  logic [COORD_W-1:0]   radius;
  logic                 outline;
  logic [BYTE_W-1:0]    paint, rd_row, rd_col;
  logic [CW-1:0]        col;
  logic [RW-1:0]        row;
  logic [SW-1:0]        cxsq, dxsq, dysq, r_sq, inner_sq;
  logic                 inner_neg;
  logic [1:0]           step;
  logic [BYTE_W-1:0]    res_pixel;
  logic [STATUS_W-1:0]  res_status;

  logic                  col_last, row_last;
  logic [SW-1:0]         d_sq, dxsq_step, dysq_step;
  logic [SW:0]           dxsq_sum, dysq_sum;
  logic                  hit;
  logic [DMW-1:0]        rd_row_x, rd_col_x;
  logic                  rd_outside;
  logic signed [PW-1:0]  r_ext, inner, mul_op;
  logic signed [SW-1:0]  mul_prod;
  logic                  accept, out_free, advance;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  assign in_cx      = s_tdata[19:0];
  assign in_cy      = s_tdata[39:20];
  assign in_radius  = s_tdata[59:40];
  assign in_outline = s_tdata[60];
  assign in_paint   = s_tdata[68:61];
  assign in_row     = s_tdata[76:69];
  assign in_col     = s_tdata[84:77];

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= WIDTH_RESET;
      canvas_height   <= HEIGHT_RESET;
      background_byte <= BACKGROUND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:      canvas_width    <= cfg_data;
        REG_HEIGHT:     canvas_height   <= cfg_data;
        REG_BACKGROUND: background_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cols_used  = (DMW'(canvas_width) > MAX_COLS) ? MAX_COLS : DMW'(canvas_width);
  assign rows_used  = (DMW'(canvas_height) > MAX_ROWS) ? MAX_ROWS : DMW'(canvas_height);
  assign dims_empty = (cols_used == '0) || (rows_used == '0);

  assign col_last = (DMW'(col) + DMW'(1)) == cols_used;
  assign row_last = (DMW'(row) + DMW'(1)) == rows_used;

  // (d + 256)^2 = d^2 + 512*d + 65536
  assign dxsq_sum  = {1'b0, dxsq} + {{(SW - PW - FRAC_BITS){dx[PW-1]}}, dx, (FRAC_BITS + 1)'(0)}
                     + STEP_SQ;
  assign dysq_sum  = {1'b0, dysq} + {{(SW - PW - FRAC_BITS){dy[PW-1]}}, dy, (FRAC_BITS + 1)'(0)}
                     + STEP_SQ;
  assign dxsq_step = dxsq_sum[SW-1:0];
  assign dysq_step = dysq_sum[SW-1:0];

  assign d_sq = dxsq + dysq;
  assign hit  = (d_sq <= r_sq) && !(outline && !inner_neg && (d_sq <= inner_sq));

  assign rd_row_x   = DMW'(rd_row);
  assign rd_col_x   = DMW'(rd_col);
  assign rd_outside = (rd_row_x >= rows_used) || (rd_col_x >= cols_used);

  assign r_ext = $signed({{(PW - COORD_W){1'b0}}, radius});
  assign inner = r_ext - $signed(PIX_STEP);

  always_comb begin
    unique case (step)
      2'd0:    mul_op = dx0;
      2'd1:    mul_op = dy;
      2'd2:    mul_op = r_ext;
      default: mul_op = inner;
    endcase
  end

  assign mul_prod = mul_op * mul_op;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign advance  = (state == ST_FILL) || (state == ST_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    ram_wdata  = background_byte;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_tuser)
            OP_CLEAR: state_next = dims_empty ? ST_DONE : ST_FILL;
            OP_DRAW:  state_next = (in_radius == '0 || dims_empty) ? ST_DONE : ST_SETUP;
            OP_READ:  state_next = ST_RD_ADDR;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (col_last && row_last) begin
          state_next = ST_DONE;
        end
      end
      ST_SETUP: begin
        if (step == 2'd3) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram_we    = hit;
        ram_wdata = paint;
        if (col_last && row_last) begin
          state_next = ST_DONE;
        end
      end
      ST_RD_ADDR: state_next = rd_outside ? ST_DONE : ST_RD_DATA;
      ST_RD_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx0        <= -$signed({{(PW - COORD_W){in_cx[COORD_W-1]}}, in_cx});
      dy         <= -$signed({{(PW - COORD_W){in_cy[COORD_W-1]}}, in_cy});
      radius     <= in_radius;
      outline    <= in_outline;
      paint      <= in_paint;
      rd_row     <= in_row;
      rd_col     <= in_col;
      col        <= '0;
      row        <= '0;
      step       <= '0;
      res_pixel  <= '0;
      res_status <= (s_tuser == OP_DRAW && in_radius == '0) ? STAT_BAD_RADIUS : STAT_OK;
    end
    if (state == ST_SETUP) begin
      step <= step + 2'd1;
      unique case (step)
        2'd0: begin
          cxsq <= mul_prod;
          dxsq <= mul_prod;
          dx   <= dx0;
        end
        2'd1: dysq <= mul_prod;
        2'd2: r_sq <= mul_prod;
        default: begin
          inner_sq  <= mul_prod;
          inner_neg <= inner[PW-1];
        end
      endcase
    end
    if (advance) begin
      if (col_last) begin
        col  <= '0;
        dx   <= dx0;
        dxsq <= cxsq;
        row  <= row + RW'(1);
        dy   <= dy + $signed(PIX_STEP);
        dysq <= dysq_step;
      end else begin
        col  <= col + CW'(1);
        dx   <= dx + $signed(PIX_STEP);
        dxsq <= dxsq_step;
      end
    end
    if (state == ST_RD_ADDR && rd_outside) begin
      res_status <= STAT_OUTSIDE;
    end
    if (state == ST_RD_DATA) begin
      res_pixel <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= res_pixel;
      m_tuser <= res_status;
    end
  end

  assign ram_waddr = {row, col};
  assign ram_raddr = {rd_row_x[RW-1:0], rd_col_x[CW-1:0]};

  ccr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 ** AW)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the circle canvas rasterizer: directed shapes, sizes, random traffic.
module testbench import ccr_pkg::*; ();

  localparam int CANVAS_MAX    = 256;
  localparam int STALL_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;

  localparam logic [OPCODE_W-1:0]    OP_SPARE  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0]       opcode;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [COORD_W-1:0]        radius;
    logic                      outline_only;
    logic [BYTE_W-1:0]         paint_byte;
    logic [BYTE_W-1:0]         read_row;
    logic [BYTE_W-1:0]         read_col;
  } canvas_cmd_t;

  typedef struct {
    logic [BYTE_W-1:0]   pixel_value;
    logic [STATUS_W-1:0] status;
  } pixel_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [OPCODE_W-1:0]    s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]    m_tuser;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // predicted block state
  logic [BYTE_W-1:0] canvas_px [CANVAS_MAX*CANVAS_MAX];
  logic [CFG_W-1:0]  canvas_cols = WIDTH_RESET;
  logic [CFG_W-1:0]  canvas_rows = HEIGHT_RESET;
  logic [BYTE_W-1:0] canvas_bg   = BACKGROUND_RESET;

  pixel_result_t pending_results[$];
  pixel_result_t want_word;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int words_checked  = 0;
  int settings_used  = 1;
  int ops_sent [4]   = '{0, 0, 0, 0};

  circle_canvas_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cols_in_use();
    return (canvas_cols > CANVAS_MAX) ? CANVAS_MAX : int'(canvas_cols);
  endfunction

  function automatic int rows_in_use();
    return (canvas_rows > CANVAS_MAX) ? CANVAS_MAX : int'(canvas_rows);
  endfunction

  // Runs one command on the predicted canvas and returns the word it should produce.
  function automatic pixel_result_t apply_command(canvas_cmd_t c);
    pixel_result_t res;
    longint cx, cy, r, r_sq, inner, inner_sq, dx, dy, d_sq;
    int cols, rows, x, y;
    res.pixel_value = '0;
    res.status = STAT_OK;
    cols = cols_in_use();
    rows = rows_in_use();
    case (c.opcode)
      OP_CLEAR: begin
        for (y = 0; y < rows; y++)
          for (x = 0; x < cols; x++)
            canvas_px[y*CANVAS_MAX + x] = canvas_bg;
      end
      OP_DRAW: begin
        if (c.radius == 0) begin
          res.status = STAT_BAD_RADIUS;
        end else begin
          cx = c.center_x;
          cy = c.center_y;
          r = c.radius;
          r_sq = r * r;
          inner = r - (1 << FRAC_BITS);
          inner_sq = inner * inner;
          for (y = 0; y < rows; y++) begin
            dy = longint'(y) * (1 << FRAC_BITS) - cy;
            for (x = 0; x < cols; x++) begin
              dx = longint'(x) * (1 << FRAC_BITS) - cx;
              d_sq = dx * dx + dy * dy;
              if (d_sq > r_sq) continue;
              if (c.outline_only && inner >= 0 && d_sq <= inner_sq) continue;
              canvas_px[y*CANVAS_MAX + x] = c.paint_byte;
            end
          end
        end
      end
      OP_READ: begin
        if (c.read_row >= rows || c.read_col >= cols)
          res.status = STAT_OUTSIDE;
        else
          res.pixel_value = canvas_px[int'(c.read_row)*CANVAS_MAX + int'(c.read_col)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic canvas_cmd_t noise_cmd(logic [OPCODE_W-1:0] op);
    canvas_cmd_t c;
    c.opcode = op;
    c.center_x = COORD_W'($urandom);
    c.center_y = COORD_W'($urandom);
    c.radius = COORD_W'($urandom);
    c.outline_only = 1'($urandom_range(1));
    c.paint_byte = BYTE_W'($urandom);
    c.read_row = BYTE_W'($urandom);
    c.read_col = BYTE_W'($urandom);
    return c;
  endfunction

  // Mostly circles near the canvas and reads inside it; the rest is full-range noise.
  function automatic canvas_cmd_t random_command();
    canvas_cmd_t c;
    int cols, rows, span, k;
    cols = cols_in_use();
    rows = rows_in_use();
    span = ((cols > rows) ? cols : rows) + 2;
    k = $urandom_range(99);
    c = noise_cmd(k < 8 ? OP_CLEAR : k < 45 ? OP_DRAW : k < 95 ? OP_READ : OP_SPARE);
    if (c.opcode == OP_DRAW) begin
      if ($urandom_range(9) != 0) begin
        c.center_x = COORD_W'($urandom_range((cols + 6) * 256) - 3 * 256);
        c.center_y = COORD_W'($urandom_range((rows + 6) * 256) - 3 * 256);
      end
      k = $urandom_range(11);
      if (k == 0)
        c.radius = '0;
      else if (k > 1)
        c.radius = COORD_W'($urandom_range(span * 256, 1));
    end else if (c.opcode == OP_READ) begin
      if (cols > 0 && rows > 0 && $urandom_range(4) != 0) begin
        c.read_row = BYTE_W'($urandom_range(rows - 1));
        c.read_col = BYTE_W'($urandom_range(cols - 1));
      end
    end
    return c;
  endfunction

  // Valid stays high on return so back-to-back words need no extra edge.
  task automatic send_command(canvas_cmd_t c);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(12, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.opcode;
    s_tdata <= {3'b000, c.read_col, c.read_row, c.paint_byte, c.outline_only,
                c.radius, c.center_y, c.center_x};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_command(c));
    ops_sent[c.opcode]++;
  endtask

  task automatic do_clear();
    send_command(noise_cmd(OP_CLEAR));
  endtask

  task automatic do_draw(int cx, int cy, int r, bit outline, logic [BYTE_W-1:0] paint);
    canvas_cmd_t c;
    c = noise_cmd(OP_DRAW);
    c.center_x = COORD_W'(cx);
    c.center_y = COORD_W'(cy);
    c.radius = COORD_W'(r);
    c.outline_only = outline;
    c.paint_byte = paint;
    send_command(c);
  endtask

  task automatic do_read(int row, int col);
    canvas_cmd_t c;
    c = noise_cmd(OP_READ);
    c.read_row = BYTE_W'(row);
    c.read_col = BYTE_W'(col);
    send_command(c);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_canvas(int cols, int rows, int bg);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= CFG_W'(cols);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= REG_BACKGROUND;
    cfg_data <= CFG_W'(bg & 8'hFF);
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    canvas_cols = CFG_W'(cols);
    canvas_rows = CFG_W'(rows);
    canvas_bg = BYTE_W'(bg);
    settings_used++;
  endtask

  // Full canvas with reset settings; also makes every pixel defined.
  task automatic test_reset_canvas();
    do_clear();
    do_read(0, 0);
    do_read(255, 255);
    do_read(0, 255);
    do_read(255, 0);
  endtask

  task automatic test_shapes();
    wait_idle();
    set_canvas(16, 12, 8'h2E);
    do_clear();
    do_draw(7*256 + 128, 5*256, 4*256 + 64, 0, 8'h41);
    do_draw(3*256, 8*256 + 200, 3*256, 1, 8'h62);
    do_draw(12*256 + 100, 2*256, 200, 1, 8'h7A);    // outline below one pixel
    do_draw(10*256, 10*256, 2*256, 1, 8'h00);       // ring on exact integer distances
    do_draw(5*256, 5*256, 0, 0, 8'hFF);             // rejected radius
    do_read(5, 7);
    do_read(9, 3);
    do_read(2, 12);
    do_read(10, 12);
    do_read(8, 10);
    do_draw(-524288, 524287, 1048575, 1, 8'hFF);
    do_draw(524287, -524288, 1048575, 0, 8'h3C);
    do_read(11, 15);
    do_read(12, 3);
    do_read(4, 16);
    do_read(255, 255);
    send_command(noise_cmd(OP_SPARE));
  endtask

  task automatic test_empty_canvas();
    wait_idle();
    set_canvas(0, 7, 8'h11);
    do_clear();
    do_draw(256, 256, 3*256, 0, 8'h55);
    do_read(0, 0);
    wait_idle();
    set_canvas(9, 0, 8'h00);
    do_clear();
    do_draw(256, 256, 3*256, 0, 8'h55);
    do_read(0, 0);
  endtask

  // Register values above the maximum are capped; pixels outside the old size keep their data.
  task automatic test_oversize_canvas();
    wait_idle();
    set_canvas(300, 511, 8'hFF);
    do_draw(127*256 + 128, 127*256 + 128, 90*256, 0, 8'hC3);
    do_read(127, 127);
    do_read(0, 0);
    do_read(255, 255);
    do_read(127, 218);
    do_read(200, 60);
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_stall_pct <= 0;
    set_canvas(8, 8, 8'h5A);
    hold_requests <= hold_requests + 1;
    do_clear();
    do_draw(3*256, 4*256, 2*256 + 128, 0, 8'h21);
    do_draw(6*256, 1*256, 3*256, 1, 8'h43);
    do_read(4, 3);
    do_read(1, 6);
    do_draw(0, 0, 5*256, 1, 8'h65);
    do_read(0, 4);
    do_read(7, 7);
    do_read(3, 0);
    do_read(8, 8);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    int cols, rows;
    wait_idle();
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    if ($urandom_range(3) == 0) begin
      cols = $urandom_range(511, 257);
      rows = $urandom_range(3, 1);
    end else begin
      cols = $urandom_range(20, 1);
      rows = $urandom_range(20, 1);
    end
    set_canvas(cols, rows, $urandom_range(255));
    do_clear();
    repeat (count) send_command(random_command());
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_checked++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("word %0d: none expected, got pixel %02h status %0d",
                   words_checked, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want_word = pending_results.pop_front();
        if (m_tdata !== want_word.pixel_value || m_tuser !== want_word.status) begin
          if (mismatches < 10)
            $display("word %0d: expected pixel %02h status %0d, got pixel %02h status %0d",
                     words_checked, want_word.pixel_value, want_word.status, m_tdata, m_tuser);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_canvas();
    test_shapes();
    test_empty_canvas();
    test_oversize_canvas();
    test_output_backpressure();
    test_random_phase(0, 0, 13);
    test_random_phase(68, 0, 13);
    test_random_phase(0, 68, 13);
    test_random_phase(26, 26, 13);
    wait_idle();
    if (pending_results.size() != 0) begin
      $display("%0d words never arrived", pending_results.size());
      mismatches++;
    end
    $display("sent %0d clear, %0d draw, %0d read, %0d spare opcode; %0d words checked",
             ops_sent[OP_CLEAR], ops_sent[OP_DRAW], ops_sent[OP_READ], ops_sent[OP_SPARE],
             words_checked);
    $display("%0d canvas settings incl. empty and capped sizes, one %0d-cycle output hold",
             settings_used, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
